// ----- sv/timed_waypoint_path_interpolator_assert.svh -----
// Assertion macros shared by the waypoint path interpolator.
`ifndef TIMED_WAYPOINT_PATH_INTERPOLATOR_ASSERT_SVH
`define TIMED_WAYPOINT_PATH_INTERPOLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWPI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWPI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/twpi_pkg.sv -----
// Shared types and constants of the waypoint path interpolator.
package twpi_pkg;

	localparam int MAX_WAYPOINTS_DEF = 16;
	localparam int COUNT_W = 5;
	localparam int TIME_W = 16;
	localparam int INDEX_W = 4;
	localparam int POS_W = 24;
	localparam int STEP_W = 25;
	localparam int SEG_OUT_W = 4;
	localparam int ELAPSED_W = 17;
	localparam int Q_FRAC = 16;
	localparam int PROG_W = Q_FRAC + 1;
	localparam int PROD_W = STEP_W + PROG_W + 1;
	localparam int DIV_STEPS = Q_FRAC;
	localparam int DIV_CNT_W = 5;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
	localparam logic [PROG_W-1:0] ONE_Q16 = PROG_W'(1) << Q_FRAC;
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [TIME_W-1:0] dur;
	} twpi_entry_t;

	localparam int ENTRY_W = $bits(twpi_entry_t);

	typedef struct packed {
		logic accept_tick;
		logic write_entry;
		logic rd_en;
		logic rd_prev;
		logic advance;
		logic load_cur;
		logic load_prev;
		logic div_step;
		logic multiply;
		logic finish;
	} twpi_cmd_t;

	typedef struct packed {
		logic div_done;
	} twpi_status_t;

endpackage

// ----- sv/twpi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module twpi_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/twpi_datapath.sv -----
// Datapath: waypoint table, segment timing, progress divider and interpolation.
module twpi_datapath
	import twpi_pkg::*;
#(
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF,
	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1,
	localparam int CW = $clog2(MAX_WAYPOINTS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  twpi_cmd_t                   cmd,
	output twpi_status_t                status,
	input  logic                        cfg_wr_en,
	input  logic [COUNT_W-1:0]          cfg_wr_data,
	input  logic [TIME_W-1:0]           delta_time,
	input  logic [INDEX_W-1:0]          waypoint_index,
	input  logic signed [POS_W-1:0]     waypoint_x,
	input  logic signed [POS_W-1:0]     waypoint_y,
	input  logic [TIME_W-1:0]           waypoint_duration,
	output logic                        done,
	output logic signed [POS_W-1:0]     position_x,
	output logic signed [POS_W-1:0]     position_y,
	output logic signed [STEP_W-1:0]    step_x,
	output logic signed [STEP_W-1:0]    step_y,
	output logic [SEG_OUT_W-1:0]        segment
);

	logic [COUNT_W-1:0] waypoint_count_q;
	logic [CW-1:0] count_eff;
	logic [AW-1:0] seg_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic signed [POS_W-1:0] last_x_q;
	logic signed [POS_W-1:0] last_y_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic done_q;

	logic signed [POS_W-1:0] cur_x_q;
	logic signed [POS_W-1:0] cur_y_q;
	logic [TIME_W-1:0] dur_q;
	logic signed [POS_W-1:0] prev_x_q;
	logic signed [POS_W-1:0] prev_y_q;
	logic [TIME_W-1:0] rem_q;
	logic [PROG_W-1:0] quo_q;
	logic signed [PROD_W-1:0] prod_x_q;
	logic signed [PROD_W-1:0] prod_y_q;
	logic signed [POS_W-1:0] position_x_q;
	logic signed [POS_W-1:0] position_y_q;
	logic signed [STEP_W-1:0] step_x_q;
	logic signed [STEP_W-1:0] step_y_q;
	logic [SEG_OUT_W-1:0] segment_q;

	logic wr_en;
	logic [AW-1:0] wr_addr;
	twpi_entry_t wr_entry;
	logic [AW-1:0] rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	twpi_entry_t rd_entry;

	logic [ELAPSED_W:0] elapsed_sum;
	logic seg_out_of_range;
	logic seg_wrap;
	logic div_sat;
	logic [TIME_W:0] rem_dbl;
	logic div_ge;
	logic signed [STEP_W-1:0] diff_x;
	logic signed [STEP_W-1:0] diff_y;
	logic signed [PROD_W-1:0] quo_wide;
	logic signed [POS_W-1:0] new_x;
	logic signed [POS_W-1:0] new_y;

	always_comb begin
		priority if (waypoint_count_q == '0) begin
			count_eff = CW'(1);
		end else if (32'(waypoint_count_q) > MAX_WAYPOINTS) begin
			count_eff = CW'(MAX_WAYPOINTS);
		end else begin
			count_eff = CW'(waypoint_count_q);
		end
	end

	assign wr_en = cmd.write_entry && (32'(waypoint_index) < MAX_WAYPOINTS);
	assign wr_addr = AW'(waypoint_index);
	assign wr_entry = '{x: waypoint_x, y: waypoint_y, dur: waypoint_duration};
	assign rd_addr = cmd.rd_prev ? seg_q - AW'(1) : seg_q;
	assign rd_entry = twpi_entry_t'(rd_data);

	twpi_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_WAYPOINTS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign elapsed_sum = {1'b0, elapsed_q} + (ELAPSED_W + 1)'(delta_time);
	assign seg_out_of_range = 32'(seg_q) >= 32'(count_eff);
	assign seg_wrap = (32'(seg_q) + 32'd1) >= 32'(count_eff);
	assign div_sat = (dur_q == '0) || (elapsed_q >= ELAPSED_W'(dur_q));
	assign rem_dbl = {rem_q, 1'b0};
	assign div_ge = rem_dbl >= {1'b0, dur_q};
	assign diff_x = STEP_W'(cur_x_q) - STEP_W'(prev_x_q);
	assign diff_y = STEP_W'(cur_y_q) - STEP_W'(prev_y_q);
	assign quo_wide = PROD_W'($signed({1'b0, quo_q}));
	assign new_x = prev_x_q + prod_x_q[POS_W+Q_FRAC-1:Q_FRAC];
	assign new_y = prev_y_q + prod_y_q[POS_W+Q_FRAC-1:Q_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waypoint_count_q <= COUNT_RESET;
			seg_q <= '0;
			elapsed_q <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
			div_cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cfg_wr_en) begin
				waypoint_count_q <= cfg_wr_data;
			end
			if (cmd.accept_tick) begin
				if (seg_out_of_range) begin
					seg_q <= '0;
				end
				elapsed_q <= elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
			end
			if (cmd.advance && (elapsed_q > ELAPSED_W'(rd_entry.dur))) begin
				elapsed_q <= elapsed_q - ELAPSED_W'(rd_entry.dur);
				seg_q <= seg_wrap ? '0 : seg_q + AW'(1);
			end
			if (cmd.load_prev) begin
				div_cnt_q <= div_sat ? '0 : DIV_CNT_W'(DIV_STEPS);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end
			if (cmd.finish) begin
				last_x_q <= new_x;
				last_y_q <= new_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_cur) begin
			cur_x_q <= rd_entry.x;
			cur_y_q <= rd_entry.y;
			dur_q <= rd_entry.dur;
		end
		if (cmd.load_prev) begin
			prev_x_q <= (seg_q == '0) ? '0 : rd_entry.x;
			prev_y_q <= (seg_q == '0) ? '0 : rd_entry.y;
			rem_q <= elapsed_q[TIME_W-1:0];
			quo_q <= div_sat ? ONE_Q16 : '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? TIME_W'(rem_dbl - {1'b0, dur_q}) : rem_dbl[TIME_W-1:0];
			quo_q <= {quo_q[PROG_W-2:0], div_ge};
		end
		if (cmd.multiply) begin
			prod_x_q <= PROD_W'(diff_x) * quo_wide;
			prod_y_q <= PROD_W'(diff_y) * quo_wide;
		end
		if (cmd.finish) begin
			position_x_q <= new_x;
			position_y_q <= new_y;
			step_x_q <= STEP_W'(new_x) - STEP_W'(last_x_q);
			step_y_q <= STEP_W'(new_y) - STEP_W'(last_y_q);
			segment_q <= SEG_OUT_W'(seg_q);
		end
	end

	assign status.div_done = (div_cnt_q == '0);
	assign done = done_q;
	assign position_x = position_x_q;
	assign position_y = position_y_q;
	assign step_x = step_x_q;
	assign step_y = step_y_q;
	assign segment = segment_q;

endmodule

// ----- sv/twpi_ctrl.sv -----
// Controller state machine that issues waypoint writes and sequences one tick through the datapath.
module twpi_ctrl
	import twpi_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         command,
	input  twpi_status_t status,
	output logic         busy,
	output twpi_cmd_t    cmd
);

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b00_0000_0001,
		ST_RD_SEG    = 10'b00_0000_0010,
		ST_ADVANCE   = 10'b00_0000_0100,
		ST_RD_CUR    = 10'b00_0000_1000,
		ST_LOAD_CUR  = 10'b00_0001_0000,
		ST_RD_PREV   = 10'b00_0010_0000,
		ST_LOAD_PREV = 10'b00_0100_0000,
		ST_DIVIDE    = 10'b00_1000_0000,
		ST_MULTIPLY  = 10'b01_0000_0000,
		ST_FINISH    = 10'b10_0000_0000
	} twpi_state_t;

	twpi_state_t state_q;
	twpi_state_t state_next;

	always_comb begin
		state_next = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && (command == CMD_WRITE)) begin
					cmd.write_entry = 1'b1;
				end else if (start && (command == CMD_TICK)) begin
					cmd.accept_tick = 1'b1;
					state_next = ST_RD_SEG;
				end
			end
			ST_RD_SEG: begin
				cmd.rd_en = 1'b1;
				state_next = ST_ADVANCE;
			end
			ST_ADVANCE: begin
				cmd.advance = 1'b1;
				state_next = ST_RD_CUR;
			end
			ST_RD_CUR: begin
				cmd.rd_en = 1'b1;
				state_next = ST_LOAD_CUR;
			end
			ST_LOAD_CUR: begin
				cmd.load_cur = 1'b1;
				state_next = ST_RD_PREV;
			end
			ST_RD_PREV: begin
				cmd.rd_en = 1'b1;
				cmd.rd_prev = 1'b1;
				state_next = ST_LOAD_PREV;
			end
			ST_LOAD_PREV: begin
				cmd.load_prev = 1'b1;
				state_next = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (status.div_done) begin
					state_next = ST_MULTIPLY;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_MULTIPLY: begin
				cmd.multiply = 1'b1;
				state_next = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ----- sv/timed_waypoint_path_interpolator.sv -----
// Top level of the timed waypoint path interpolator.
//
// A waypoint write is taken straight from idle and never raises busy. A tick keeps busy
// high through the table reads, the segment advance, the loads, the divider, the
// multiply and the finish step; the restoring divider takes no step when progress
// saturates at 1.0 and otherwise forms the Q1.16 progress one bit a cycle, and three
// steps are reads of the waypoint table, which has a single read port. The result
// word appears with done for one cycle just after busy falls, and it must be taken
// then, since the receiver cannot hold it off. A new word may be started in that same cycle.
`include "timed_waypoint_path_interpolator_assert.svh"

module timed_waypoint_path_interpolator
	import twpi_pkg::*;
#(
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     cfg_wr_en,
	input  logic [COUNT_W-1:0]       cfg_wr_data,
	input  logic                     command,
	input  logic [TIME_W-1:0]        delta_time,
	input  logic [INDEX_W-1:0]       waypoint_index,
	input  logic signed [POS_W-1:0]  waypoint_x,
	input  logic signed [POS_W-1:0]  waypoint_y,
	input  logic [TIME_W-1:0]        waypoint_duration,
	output logic                     done,
	output logic signed [POS_W-1:0]  position_x,
	output logic signed [POS_W-1:0]  position_y,
	output logic signed [STEP_W-1:0] step_x,
	output logic signed [STEP_W-1:0] step_y,
	output logic [SEG_OUT_W-1:0]     segment
);

	twpi_cmd_t cmd;
	twpi_status_t status;
	logic tick_accept;
	logic write_accept;

	assign tick_accept = start && !busy && (command == CMD_TICK);
	assign write_accept = start && !busy && (command == CMD_WRITE);

	twpi_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.status  (status),
		.busy    (busy),
		.cmd     (cmd)
	);

	twpi_datapath #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.delta_time        (delta_time),
		.waypoint_index    (waypoint_index),
		.waypoint_x        (waypoint_x),
		.waypoint_y        (waypoint_y),
		.waypoint_duration (waypoint_duration),
		.done              (done),
		.position_x        (position_x),
		.position_y        (position_y),
		.step_x            (step_x),
		.step_y            (step_y),
		.segment           (segment)
	);

	`TWPI_ASSERT_NEXT(a_tick_raises_busy, tick_accept, busy, "tick word did not raise busy")
	`TWPI_ASSERT_NEXT(a_write_no_result, write_accept, !busy && !done, "write word gave a result")
	`TWPI_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe lasted more than one cycle")
	`TWPI_ASSERT_SAME(a_done_after_busy, done, !busy && $past(busy), "stray result strobe")

endmodule
